// ===== design/gwwl_pkg.sv =====
`default_nettype none

package gwwl_pkg;

  localparam logic [15:0] CODE_NEWLINE = 16'd10;
  localparam logic [15:0] CODE_SPACE   = 16'd32;

  localparam logic KIND_PLACE   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // register index taken from paddr[2]
  localparam logic REG_MAX_WIDTH = 1'b0;
  localparam logic REG_BREAK_NL  = 1'b1;

  localparam int unsigned MAX_WIDTH_W = 14;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

endpackage

`default_nettype wire

// ===== design/greedy_word_wrap_line_unit.sv =====
// Greedy word-wrap line unit.
// Input channel (in_valid_i / in_stall_o): one character word per accepted
// cycle with its glyph metrics, kerning and end-of-text mark.
// Output channel (out_valid_o / out_stall_i): result words, either a glyph
// placement (kind 0) or a line summary (kind 1); run_last_o marks the final
// result of an input word. An input word gives zero, one or two results.
// The first result of a word is offered once the word has passed from the
// input register into the result queue. Throughput: one input word per
// cycle while every word gives at most one result and the receiver does
// not stall; a word with two results uses the single output port twice,
// so the rate is set by the one-result-per-cycle output.
// A 4-entry result queue sits between the input register and the output;
// the input register is taken by the processing step only when the queue has
// room for two results, so a stalled receiver backs up the queue and then the
// input register, after which in_stall_o rises. Nothing is lost or repeated.
// Reset clears the line state, the queue and the input register, sets
// max_width to 0 (unlimited) and break_on_newline to 1.
// Configuration uses the APB port: max_width at 0x0, break_on_newline at 0x4.
`default_nettype none

module greedy_word_wrap_line_unit
  import gwwl_pkg::*;
#(
  parameter int unsigned LINE_GLYPHS = 256,
  localparam int unsigned CntW = $clog2(LINE_GLYPHS + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,

  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [15:0]           char_index_i,
  input  wire logic [15:0]           char_code_i,
  input  wire logic                  glyph_present_i,
  input  wire logic [9:0]            glyph_w_i,
  input  wire logic [9:0]            glyph_h_i,
  input  wire logic signed [9:0]     bearing_x_i,
  input  wire logic [9:0]            advance_x_i,
  input  wire logic signed [8:0]     kern_x_i,
  input  wire logic                  text_end_i,

  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       kind_o,
  output logic [15:0]                placed_code_o,
  output logic signed [15:0]         place_x_o,
  output logic [9:0]                 place_w_o,
  output logic [9:0]                 place_h_o,
  output logic [CntW-1:0]            keep_count_o,
  output logic [16:0]                next_start_o,
  output logic [14:0]                line_w_o,
  output logic [9:0]                 line_h_o,
  output logic                       run_last_o
);

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned FcntW     = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic              kind;
    logic [15:0]       code;
    logic [15:0]       x;
    logic [9:0]        w;
    logic [9:0]        h;
    logic [CntW-1:0]   keep;
    logic [16:0]       next;
    logic [14:0]       lw;
    logic [9:0]        lh;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [15:0]       idx;
    logic [15:0]       code;
    logic              present;
    logic [9:0]        gw;
    logic [9:0]        gh;
    logic signed [9:0] bear;
    logic [9:0]        adv;
    logic signed [8:0] kern;
    logic              tend;
  } item_t;

  function automatic logic signed [16:0] sat17(input logic signed [17:0] v);
    if (v > 18'sd65535) begin
      return 17'sd65535;
    end else if (v < -18'sd65536) begin
      return -17'sd65536;
    end else begin
      return v[16:0];
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sd32767;
    end else if (v < -18'sd32768) begin
      return -16'sd32768;
    end else begin
      return v[15:0];
    end
  endfunction

  // configuration
  logic [MAX_WIDTH_W-1:0] max_width_q;
  logic                   break_nl_q;
  logic                   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_MAX_WIDTH: prdata = {{(APB_DATA_W-MAX_WIDTH_W){1'b0}}, max_width_q};
      REG_BREAK_NL:  prdata = {{(APB_DATA_W-1){1'b0}}, break_nl_q};
      default:       prdata = '0;
    endcase
  end

  // input register and result queue control
  item_t             item_q;
  logic              in_vld_q;
  logic              fire;
  logic              in_accept;
  res_t              fifo_q [FifoDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FcntW-1:0]  cnt_q;
  logic              pop;

  assign fire       = in_vld_q && (cnt_q <= FcntW'(FifoDepth - 2));
  assign in_stall_o = in_vld_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  // line state
  logic signed [16:0] pen_q, pen_d;
  logic [CntW-1:0]    placed_q, placed_d;
  logic [16:0]        ws_idx_q, ws_idx_d;
  logic [CntW-1:0]    ws_cnt_q, ws_cnt_d;
  logic [14:0]        rw_q, rw_d;
  logic [9:0]         rh_q, rh_d;
  logic [14:0]        pfx_w_q, pfx_w_d;
  logic [9:0]         pfx_h_q, pfx_h_d;
  logic [14:0]        snap_w_q, snap_w_d;
  logic [9:0]         snap_h_q, snap_h_d;

  // datapath
  logic               is_nl, is_sp, nl_brk, ovf;
  logic [9:0]         gw, gh;
  logic signed [18:0] room;
  logic signed [17:0] pen_gw, rw_max, pen_k, px_sum, pen_a;
  logic [14:0]        rw_new;
  logic [9:0]         rh_new;
  logic signed [16:0] pen1;
  logic signed [15:0] px;
  logic signed [16:0] pw_sum;
  logic [14:0]        pw_clip, pw_new;
  logic [9:0]         ph_new;
  logic [16:0]        idx_p1;
  logic [CntW-1:0]    placed_p1;
  logic               clr;
  logic [1:0]         n_res;
  res_t               r0, r1;

  always_comb begin
    is_nl  = item_q.code == CODE_NEWLINE;
    is_sp  = item_q.code == CODE_SPACE;
    gw     = is_nl ? 10'd0 : item_q.gw;
    gh     = is_nl ? 10'd0 : item_q.gh;
    nl_brk = break_nl_q && is_nl;
    room   = $signed({5'b0, max_width_q}) - $signed({{2{pen_q[16]}}, pen_q});
    ovf    = (max_width_q != '0) && (room < $signed({9'b0, gw}));

    pen_gw = $signed({pen_q[16], pen_q}) + $signed({8'b0, gw});
    rw_max = (pen_gw > $signed({3'b0, rw_q})) ? pen_gw : $signed({3'b0, rw_q});
    rw_new = (rw_max > 18'sd32767) ? 15'd32767 : rw_max[14:0];
    rh_new = (gh > rh_q) ? gh : rh_q;

    pen_k  = $signed({pen_q[16], pen_q}) + $signed({{9{item_q.kern[8]}}, item_q.kern});
    pen1   = sat17(pen_k);
    px_sum = $signed({pen1[16], pen1}) +
             (item_q.bear[9] ? $signed({{8{item_q.bear[9]}}, item_q.bear}) : 18'sd0);
    px     = sat16(px_sum);
    pw_sum = $signed({px[15], px}) + $signed({7'b0, gw});
    pw_clip = pw_sum[16] ? 15'd0 : pw_sum[15] ? 15'd32767 : pw_sum[14:0];
    pw_new = (pw_clip > pfx_w_q) ? pw_clip : pfx_w_q;
    ph_new = (gh > pfx_h_q) ? gh : pfx_h_q;
    pen_a  = $signed({pen1[16], pen1}) + $signed({8'b0, item_q.adv});

    idx_p1    = {1'b0, item_q.idx} + 17'd1;
    placed_p1 = placed_q + CntW'(1);

    pen_d    = pen_q;
    placed_d = placed_q;
    ws_idx_d = ws_idx_q;
    ws_cnt_d = ws_cnt_q;
    rw_d     = rw_q;
    rh_d     = rh_q;
    pfx_w_d  = pfx_w_q;
    pfx_h_d  = pfx_h_q;
    snap_w_d = snap_w_q;
    snap_h_d = snap_h_q;
    r0       = '0;
    r1       = '0;
    n_res    = 2'd0;
    clr      = 1'b0;

    if (fire) begin
      if ((is_nl || item_q.present) && (nl_brk || ovf)) begin
        r0.kind = KIND_SUMMARY;
        if (!is_nl && !is_sp && ws_cnt_q != '0) begin
          // cut back to the last word start
          r0.keep = ws_cnt_q;
          r0.next = ws_idx_q;
          r0.lw   = snap_w_q;
          r0.lh   = snap_h_q;
        end else begin
          r0.keep = placed_q;
          r0.next = nl_brk ? idx_p1 : {1'b0, item_q.idx};
          r0.lw   = rw_q;
          r0.lh   = rh_q;
        end
        n_res = 2'd1;
        clr   = 1'b1;
      end else if (item_q.present && !is_nl && placed_q == CntW'(LINE_GLYPHS)) begin
        r0.kind = KIND_SUMMARY;
        r0.keep = placed_q;
        r0.next = {1'b0, item_q.idx};
        r0.lw   = rw_q;
        r0.lh   = rh_q;
        n_res   = 2'd1;
        clr     = 1'b1;
      end else if (item_q.present && !is_nl) begin
        r0.kind  = KIND_PLACE;
        r0.code  = item_q.code;
        r0.x     = px;
        r0.w     = gw;
        r0.h     = gh;
        n_res    = 2'd1;
        rw_d     = rw_new;
        rh_d     = rh_new;
        pfx_w_d  = pw_new;
        pfx_h_d  = ph_new;
        placed_d = placed_p1;
        pen_d    = sat17(pen_a);
        if (is_sp) begin
          ws_idx_d = idx_p1;
          ws_cnt_d = placed_p1;
          snap_w_d = pw_new;
          snap_h_d = ph_new;
        end
        if (item_q.tend) begin
          r1.kind = KIND_SUMMARY;
          r1.keep = placed_p1;
          r1.next = idx_p1;
          r1.lw   = rw_new;
          r1.lh   = rh_new;
          n_res   = 2'd2;
          clr     = 1'b1;
        end
      end else if (item_q.tend) begin
        r0.kind = KIND_SUMMARY;
        r0.keep = placed_q;
        r0.next = idx_p1;
        r0.lw   = rw_q;
        r0.lh   = rh_q;
        n_res   = 2'd1;
        clr     = 1'b1;
      end

      if (n_res == 2'd1) begin
        r0.last = 1'b1;
      end
      if (n_res == 2'd2) begin
        r1.last = 1'b1;
      end

      if (clr) begin
        pen_d    = '0;
        placed_d = '0;
        ws_idx_d = '0;
        ws_cnt_d = '0;
        rw_d     = '0;
        rh_d     = '0;
        pfx_w_d  = '0;
        pfx_h_d  = '0;
        snap_w_d = '0;
        snap_h_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_width_q <= '0;
      break_nl_q  <= 1'b1;
      in_vld_q    <= 1'b0;
      pen_q       <= '0;
      placed_q    <= '0;
      ws_idx_q    <= '0;
      ws_cnt_q    <= '0;
      rw_q        <= '0;
      rh_q        <= '0;
      pfx_w_q     <= '0;
      pfx_h_q     <= '0;
      snap_w_q    <= '0;
      snap_h_q    <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          REG_MAX_WIDTH: max_width_q <= pwdata[MAX_WIDTH_W-1:0];
          REG_BREAK_NL:  break_nl_q  <= pwdata[0];
          default:       max_width_q <= max_width_q;
        endcase
      end
      if (in_accept) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      pen_q    <= pen_d;
      placed_q <= placed_d;
      ws_idx_q <= ws_idx_d;
      ws_cnt_q <= ws_cnt_d;
      rw_q     <= rw_d;
      rh_q     <= rh_d;
      pfx_w_q  <= pfx_w_d;
      pfx_h_q  <= pfx_h_d;
      snap_w_q <= snap_w_d;
      snap_h_q <= snap_h_d;
      wr_ptr_q <= wr_ptr_q + PtrW'(n_res);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + FcntW'(n_res) - FcntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.idx     <= char_index_i;
      item_q.code    <= char_code_i;
      item_q.present <= glyph_present_i;
      item_q.gw      <= glyph_w_i;
      item_q.gh      <= glyph_h_i;
      item_q.bear    <= bearing_x_i;
      item_q.adv     <= advance_x_i;
      item_q.kern    <= kern_x_i;
      item_q.tend    <= text_end_i;
    end
    if (n_res != 2'd0) begin
      fifo_q[wr_ptr_q] <= r0;
    end
    if (n_res == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= r1;
    end
  end

  assign out_valid_o   = cnt_q != '0;
  assign kind_o        = fifo_q[rd_ptr_q].kind;
  assign placed_code_o = fifo_q[rd_ptr_q].code;
  assign place_x_o     = $signed(fifo_q[rd_ptr_q].x);
  assign place_w_o     = fifo_q[rd_ptr_q].w;
  assign place_h_o     = fifo_q[rd_ptr_q].h;
  assign keep_count_o  = fifo_q[rd_ptr_q].keep;
  assign next_start_o  = fifo_q[rd_ptr_q].next;
  assign line_w_o      = fifo_q[rd_ptr_q].lw;
  assign line_h_o      = fifo_q[rd_ptr_q].lh;
  assign run_last_o    = fifo_q[rd_ptr_q].last;

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FcntW'(FifoDepth))
    else $error("result queue overfilled");

  a_placed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    placed_q <= CntW'(LINE_GLYPHS))
    else $error("placed count beyond line store");

  a_word_start_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ws_cnt_q != '0) |-> (ws_cnt_q <= placed_q))
    else $error("word start count exceeds placed count");

  a_two_results_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_res == 2'd2) |=> (cnt_q >= FcntW'(2)) || $past(pop))
    else $error("second result of a word dropped");
`endif

endmodule

`default_nettype wire
